@@ src/tstk_pkg.sv @@
// Package for the transactional stack: item types, function codes and status codes.
// No dependencies; used by transactional_stack_top and tstk_checker.
package tstk_pkg;

  localparam int WORD_W = 32;
  // A log entry is a push flag above the pushed word.
  localparam int LOG_W  = WORD_W + 1;

  // Function codes of an input item.
  localparam logic [2:0] FN_PUSH     = 3'd0;
  localparam logic [2:0] FN_POP      = 3'd1;
  localparam logic [2:0] FN_TOP      = 3'd2;
  localparam logic [2:0] FN_CLEAR    = 3'd3;
  localparam logic [2:0] FN_BEGIN    = 3'd4;
  localparam logic [2:0] FN_COMMIT   = 3'd5;
  localparam logic [2:0] FN_ROLLBACK = 3'd6;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LOGGED = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_NOTX   = 3'd4;
  localparam logic [2:0] ST_OVF    = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_REPLAY
  } state_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [2:0]               status;
  } rsp_t;

endpackage

@@ src/tstk_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/transactional_stack_top.sv @@
// Transactional stack: a bounded word stack with nested transactions and a replay log.
// Depends on tstk_pkg and tstk_ram (one RAM for the stack words, one for the log).
// Push, pop, top, clear, begin and rollback answer in the cycle after acceptance; an item
// may be accepted in every cycle while busy is low. A commit with log entries to replay
// keeps busy high while it reads each entry from the log RAM and applies it, and answers
// as busy falls; any other commit answers in the cycle after acceptance. Synchronous
// reset empties the stack, the log and all levels at once; RAM contents stay as they are.
module transactional_stack_top #(
  parameter int STACK_DEPTH = 256,
  parameter int LOG_DEPTH   = 64,
  parameter int MAX_NEST    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tstk_pkg::req_t request,
  output logic          done,
  output tstk_pkg::rsp_t response
);

  import tstk_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SFW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LFW = $clog2(LOG_DEPTH + 1);
  localparam int NAW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam int NW  = $clog2(MAX_NEST + 1);

  localparam logic [SFW-1:0] STACK_MAX = SFW'(STACK_DEPTH);
  localparam logic [LFW-1:0] LOG_MAX   = LFW'(LOG_DEPTH);
  localparam logic [NW-1:0]  NEST_MAX  = NW'(MAX_NEST);

  state_t state, state_next;

  logic [SFW-1:0] stack_fill, stack_fill_next;
  logic [LFW-1:0] log_fill, log_fill_next;
  logic [NW-1:0]  open_levels, open_levels_next;
  logic [LFW-1:0] replay_idx, replay_idx_next;
  logic [LFW-1:0] commit_start, commit_start_next;
  logic           apply_valid, apply_valid_next;

  logic [LFW-1:0] level_start [MAX_NEST];

  logic                     resp_valid, resp_valid_next;
  logic                     resp_ram, resp_ram_next;
  logic signed [WORD_W-1:0] resp_data, resp_data_next;
  logic [2:0]               resp_status, resp_status_next;

  logic              stk_we;
  logic [SAW-1:0]    stk_waddr;
  logic [WORD_W-1:0] stk_wdata;
  logic [SAW-1:0]    stk_raddr;
  logic [WORD_W-1:0] stk_rdata;

  logic              log_we;
  logic [LAW-1:0]    log_waddr;
  logic [LOG_W-1:0]  log_wdata;
  logic [LAW-1:0]    log_raddr;
  logic [LOG_W-1:0]  log_rdata;

  logic           lvl_we;
  logic [NW-1:0]  open_dec;
  logic [SFW-1:0] fill_dec;
  logic [LFW-1:0] lvl_top;
  logic           accept;

  // Word memory; the read port always looks at the top of the stack.
  tstk_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Action log memory; its read data is used only while a commit replays.
  tstk_ram #(.WIDTH(LOG_W), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  // Handy derived values.
  assign fill_dec  = stack_fill - 1'b1;
  assign open_dec  = open_levels - 1'b1;
  assign lvl_top   = level_start[open_dec[NAW-1:0]];
  assign stk_raddr = fill_dec[SAW-1:0];
  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);

  // Next state, memory controls and the result.
  always_comb begin
    state_next        = state;
    stack_fill_next   = stack_fill;
    log_fill_next     = log_fill;
    open_levels_next  = open_levels;
    replay_idx_next   = replay_idx;
    commit_start_next = commit_start;
    apply_valid_next  = 1'b0;
    resp_valid_next   = 1'b0;
    resp_ram_next     = 1'b0;
    resp_data_next    = '0;
    resp_status_next  = ST_OK;
    stk_we            = 1'b0;
    stk_waddr         = stack_fill[SAW-1:0];
    stk_wdata         = request.value;
    log_we            = 1'b0;
    log_waddr         = log_fill[LAW-1:0];
    log_wdata         = {1'b1, request.value};
    log_raddr         = replay_idx[LAW-1:0];
    lvl_we            = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          resp_valid_next = 1'b1;
          case (request.func)
            FN_PUSH: begin
              if (open_levels != '0) begin
                if (log_fill < LOG_MAX) begin
                  log_we           = 1'b1;
                  log_fill_next    = log_fill + 1'b1;
                  resp_status_next = ST_LOGGED;
                end else begin
                  resp_status_next = ST_OVF;
                end
              end else if (stack_fill < STACK_MAX) begin
                stk_we          = 1'b1;
                stack_fill_next = stack_fill + 1'b1;
              end else begin
                resp_status_next = ST_FULL;
              end
            end
            FN_POP: begin
              if (open_levels != '0) begin
                log_wdata = '0;
                if (log_fill < LOG_MAX) begin
                  log_we           = 1'b1;
                  log_fill_next    = log_fill + 1'b1;
                  resp_status_next = ST_LOGGED;
                end else begin
                  resp_status_next = ST_OVF;
                end
              end else if (stack_fill != '0) begin
                stack_fill_next = fill_dec;
                resp_ram_next   = 1'b1;
              end else begin
                resp_data_next   = '1;
                resp_status_next = ST_EMPTY;
              end
            end
            FN_TOP: begin
              if (open_levels != '0) begin
                resp_status_next = ST_LOGGED;
              end else if (stack_fill != '0) begin
                resp_ram_next = 1'b1;
              end else begin
                resp_data_next   = '1;
                resp_status_next = ST_EMPTY;
              end
            end
            FN_CLEAR: begin
              stack_fill_next  = '0;
              log_fill_next    = '0;
              open_levels_next = '0;
            end
            FN_BEGIN: begin
              if (open_levels < NEST_MAX) begin
                lvl_we           = 1'b1;
                open_levels_next = open_levels + 1'b1;
              end else begin
                resp_status_next = ST_OVF;
              end
            end
            FN_COMMIT: begin
              if (open_levels == '0) begin
                resp_status_next = ST_NOTX;
              end else begin
                open_levels_next  = open_dec;
                commit_start_next = lvl_top;
                if (lvl_top != log_fill) begin
                  // Entries to replay: answer once the replay is over.
                  resp_valid_next = 1'b0;
                  replay_idx_next = lvl_top;
                  state_next      = S_REPLAY;
                end
              end
            end
            FN_ROLLBACK: begin
              if (open_levels == '0) begin
                resp_status_next = ST_NOTX;
              end else begin
                log_fill_next    = lvl_top;
                open_levels_next = open_dec;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REPLAY: begin
        // Read one log entry a cycle, oldest first.
        if (replay_idx != log_fill) begin
          apply_valid_next = 1'b1;
          replay_idx_next  = replay_idx + 1'b1;
        end
        // Apply the entry read in the previous cycle.
        if (apply_valid) begin
          if (log_rdata[LOG_W-1]) begin
            stk_wdata = log_rdata[WORD_W-1:0];
            if (stack_fill < STACK_MAX) begin
              stk_we          = 1'b1;
              stack_fill_next = stack_fill + 1'b1;
            end
          end else if (stack_fill != '0) begin
            stack_fill_next = fill_dec;
          end
        end
        // All entries read and applied: drop the level's log and answer.
        if ((replay_idx == log_fill) && !apply_valid) begin
          log_fill_next   = commit_start;
          resp_valid_next = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_fill  <= '0;
      log_fill    <= '0;
      open_levels <= '0;
      apply_valid <= 1'b0;
      resp_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      stack_fill  <= stack_fill_next;
      log_fill    <= log_fill_next;
      open_levels <= open_levels_next;
      apply_valid <= apply_valid_next;
      resp_valid  <= resp_valid_next;
    end
  end

  // Payload registers and the level start table.
  always_ff @(posedge clk) begin
    replay_idx   <= replay_idx_next;
    commit_start <= commit_start_next;
    resp_ram     <= resp_ram_next;
    resp_data    <= resp_data_next;
    resp_status  <= resp_status_next;
    if (lvl_we) begin
      level_start[open_levels[NAW-1:0]] <= log_fill;
    end
  end

  // Result ports; a popped or top word comes straight from the stack RAM.
  assign done            = resp_valid;
  assign response.data   = resp_ram ? signed'(stk_rdata) : resp_data;
  assign response.status = resp_status;

endmodule

@@ src/tstk_checker.sv @@
// Port-level checks for the transactional stack, bound to the top level.
// Depends on tstk_pkg and transactional_stack_top.
module tstk_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input tstk_pkg::req_t request,
  input logic           done,
  input tstk_pkg::rsp_t response
);

  import tstk_pkg::*;

  // No result is shown while a commit is still replaying.
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result shown while busy");

  // Every item other than commit answers in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.func != FN_COMMIT)) |=> done)
    else $error("item not answered in the next cycle");

  // Only an accepted commit makes the block busy.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (request.func == FN_COMMIT)))
    else $error("busy without a commit");

  // The end of a replay carries the commit's result.
  a_replay_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done && (response.status == ST_OK)))
    else $error("replay ended without an ok result");

  // An empty answer always carries all ones.
  a_empty_data: assert property (@(posedge clk) disable iff (rst)
    (done && (response.status == ST_EMPTY)) |-> (response.data == -32'sd1))
    else $error("empty status without all-ones data");

endmodule

bind transactional_stack_top tstk_checker u_tstk_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .request  (request),
  .done     (done),
  .response (response)
);

@@ sim/tstk_check_pkg.sv @@
// Scoreboard for the transactional stack testbench: a predictor of the stack, its action
// log and its open levels, plus the queue of results it expects. Depends on tstk_pkg.
package tstk_check_pkg;
  import tstk_pkg::*;

  // Sizes the block is built with in this testbench.
  localparam int STACK_SLOTS = 256;
  localparam int LOG_SLOTS   = 64;
  localparam int NEST_LIMIT  = 8;

  // The one function code the block defines no operation for.
  localparam logic [2:0] FN_UNUSED = 3'd7;

  class tstk_scoreboard;
    logic [WORD_W-1:0] words [STACK_SLOTS];
    int unsigned       depth_used;
    logic [LOG_W-1:0]  actions [LOG_SLOTS];
    int unsigned       actions_used;
    int unsigned       level_mark [NEST_LIMIT];
    int unsigned       levels;
    rsp_t              expected_q [$];
    int unsigned       mismatches;

    function new();
      depth_used   = 0;
      actions_used = 0;
      levels       = 0;
      mismatches   = 0;
    endfunction

    function logic [2:0] push_word(logic [WORD_W-1:0] w);
      if (depth_used < STACK_SLOTS) begin
        words[depth_used] = w;
        depth_used++;
        return ST_OK;
      end
      return ST_FULL;
    endfunction

    function logic [2:0] pop_word(output logic [WORD_W-1:0] w);
      if (depth_used > 0) begin
        depth_used--;
        w = words[depth_used];
        return ST_OK;
      end
      w = '1;
      return ST_EMPTY;
    endfunction

    function logic [2:0] log_action(logic [LOG_W-1:0] entry);
      if (actions_used < LOG_SLOTS) begin
        actions[actions_used] = entry;
        actions_used++;
        return ST_LOGGED;
      end
      return ST_OVF;
    endfunction

    // Applies one accepted item to the predicted state and queues the result it must give.
    function void note_item(req_t item);
      logic [WORD_W-1:0] word;
      logic [2:0]        code;
      int unsigned       first;
      rsp_t              want;
      word = '0;
      code = ST_OK;
      case (item.func)
        FN_PUSH: begin
          if (levels > 0) code = log_action({1'b1, item.value});
          else code = push_word(item.value);
        end
        FN_POP: begin
          if (levels > 0) code = log_action('0);
          else code = pop_word(word);
        end
        FN_TOP: begin
          if (levels > 0) begin
            code = ST_LOGGED;
          end else if (depth_used > 0) begin
            word = words[depth_used - 1];
          end else begin
            word = '1;
            code = ST_EMPTY;
          end
        end
        FN_CLEAR: begin
          depth_used   = 0;
          actions_used = 0;
          levels       = 0;
        end
        FN_BEGIN: begin
          if (levels < NEST_LIMIT) begin
            level_mark[levels] = actions_used;
            levels++;
          end else begin
            code = ST_OVF;
          end
        end
        FN_COMMIT: begin
          if (levels == 0) begin
            code = ST_NOTX;
          end else begin
            // Replay the innermost level onto the stack; refused entries just do nothing.
            first = level_mark[levels - 1];
            for (int unsigned i = first; i < actions_used; i++) begin
              if (actions[i][WORD_W]) void'(push_word(actions[i][WORD_W-1:0]));
              else void'(pop_word(word));
            end
            word         = '0;
            actions_used = first;
            levels--;
          end
        end
        FN_ROLLBACK: begin
          if (levels == 0) begin
            code = ST_NOTX;
          end else begin
            actions_used = level_mark[levels - 1];
            levels--;
          end
        end
        default: ;
      endcase
      want.data   = word;
      want.status = code;
      expected_q.insert(expected_q.size(), want);
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: data %0d status %0d", got.data, got.status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.data !== want.data) begin
        $error("data mismatch: expected %0d, actual %0d", want.data, got.data);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ sim/tb.sv @@
// Testbench for transactional_stack_top: directed items, then random episodes of plain
// stack work, transactions, overflow runs and replays. Depends on tstk_pkg, tstk_check_pkg.
module tb;
  import tstk_pkg::*;
  import tstk_check_pkg::*;

  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef enum {
    EP_MIXED,
    EP_TXN,
    EP_FILL,
    EP_LOG_FULL,
    EP_NEST,
    EP_EMPTY_REPLAY
  } episode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t request = '0;
  rsp_t response;

  tstk_scoreboard sb;
  int unsigned    items_sent = 0;
  int unsigned    cycles = 0;

  transactional_stack_top #(
    .STACK_DEPTH(STACK_SLOTS),
    .LOG_DEPTH  (LOG_SLOTS),
    .MAX_NEST   (NEST_LIMIT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .response(response)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every strobed result is checked against the predictor.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(response);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("transactional_stack_top verification failed");
      $finish;
    end
  end

  // Mostly random words, with the extremes mixed in.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Offers one item, idling first at random, and returns once it has been accepted.
  task automatic send(input logic [2:0] fn, input logic [WORD_W-1:0] word);
    req_t        item;
    int unsigned idle_pct;
    item.func  = fn;
    item.value = word;
    idle_pct = (items_sent >= 700 && items_sent < 950) ? 0 : 37;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(item);
    if (fn != FN_UNUSED) items_sent++;
  endtask

  // A push, pop or top with random content.
  task automatic send_data_op();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 5) send(FN_PUSH, rand_word());
    else if (k < 9) send(FN_POP, rand_word());
    else send(FN_TOP, rand_word());
  endtask

  // Closes every open level, each by commit or rollback at random.
  task automatic close_all_levels();
    while (sb.levels > 0) begin
      if ($urandom_range(99) < 70) send(FN_COMMIT, rand_word());
      else send(FN_ROLLBACK, rand_word());
    end
  endtask

  // Holds the sender off until every expected result has come.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned lv;
    int unsigned episode;
    episode_t    kind;
    logic [2:0]  fn;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stack, no-transaction errors, extreme words, nested levels.
    send(FN_TOP, rand_word());
    send(FN_POP, rand_word());
    send(FN_COMMIT, rand_word());
    send(FN_ROLLBACK, rand_word());
    send(FN_PUSH, 32'h7FFF_FFFF);
    send(FN_PUSH, 32'h8000_0000);
    send(FN_PUSH, 32'h0000_0000);
    send(FN_PUSH, 32'hFFFF_FFFF);
    send(FN_TOP, 32'h0);
    send(FN_POP, 32'h0);
    send(FN_POP, 32'hFFFF_FFFF);
    send(FN_UNUSED, $urandom());
    send(FN_BEGIN, rand_word());
    send(FN_PUSH, 32'hA5A5_A5A5);
    send(FN_POP, rand_word());
    send(FN_TOP, rand_word());
    // An inner level with nothing logged commits at once.
    send(FN_BEGIN, rand_word());
    send(FN_COMMIT, rand_word());
    send(FN_PUSH, 32'h5A5A_5A5A);
    send(FN_COMMIT, rand_word());
    send(FN_BEGIN, rand_word());
    send(FN_PUSH, $urandom());
    send(FN_ROLLBACK, rand_word());
    send(FN_POP, rand_word());
    send(FN_CLEAR, rand_word());

    // Random episodes; the rare deep cases are forced early once each.
    episode = 0;
    while (items_sent < ITEM_TARGET) begin
      k = $urandom_range(99);
      if (episode == 1) kind = EP_FILL;
      else if (episode == 2) kind = EP_EMPTY_REPLAY;
      else if (episode == 4) kind = EP_LOG_FULL;
      else if (episode == 6) kind = EP_NEST;
      else if (k < 55) kind = EP_MIXED;
      else if (k < 80) kind = EP_TXN;
      else if (k < 83) kind = EP_FILL;
      else if (k < 89) kind = EP_LOG_FULL;
      else if (k < 94) kind = EP_NEST;
      else kind = EP_EMPTY_REPLAY;

      case (kind)
        EP_MIXED: begin
          // Any function at all, unused code included.
          n = $urandom_range(40, 20);
          repeat (n) begin
            k = $urandom_range(99);
            if (k < 30) fn = FN_PUSH;
            else if (k < 55) fn = FN_POP;
            else if (k < 63) fn = FN_TOP;
            else if (k < 66) fn = FN_CLEAR;
            else if (k < 76) fn = FN_BEGIN;
            else if (k < 86) fn = FN_COMMIT;
            else if (k < 95) fn = FN_ROLLBACK;
            else fn = FN_UNUSED;
            send(fn, rand_word());
          end
        end
        EP_TXN: begin
          // Well-formed nested transactions with random content.
          lv = $urandom_range(3, 1);
          repeat (lv) begin
            send(FN_BEGIN, rand_word());
            repeat ($urandom_range(8, 1)) send_data_op();
          end
          repeat (lv) begin
            if ($urandom_range(99) < 70) send(FN_COMMIT, rand_word());
            else send(FN_ROLLBACK, rand_word());
            repeat ($urandom_range(3, 0)) send_data_op();
          end
        end
        EP_FILL: begin
          // Fill the stack, push onto it while full, then replay pushes onto it.
          close_all_levels();
          while (sb.depth_used < STACK_SLOTS) send(FN_PUSH, rand_word());
          repeat (2) send(FN_PUSH, rand_word());
          send(FN_TOP, rand_word());
          send(FN_BEGIN, rand_word());
          repeat (3) send(FN_PUSH, rand_word());
          send(FN_COMMIT, rand_word());
          repeat ($urandom_range(40, 5)) send(FN_POP, rand_word());
        end
        EP_LOG_FULL: begin
          // Run the log past its end, then replay or discard it.
          send(FN_BEGIN, rand_word());
          n = LOG_SLOTS - sb.actions_used + $urandom_range(4, 1);
          repeat (n) begin
            if ($urandom_range(1)) send(FN_PUSH, rand_word());
            else send(FN_POP, rand_word());
          end
          close_all_levels();
        end
        EP_NEST: begin
          // Open more levels than allowed, close them all, then one close too many.
          n = NEST_LIMIT - sb.levels + $urandom_range(3, 1);
          repeat (n) begin
            send(FN_BEGIN, rand_word());
            if ($urandom_range(1)) send_data_op();
          end
          close_all_levels();
          if ($urandom_range(1)) send(FN_COMMIT, rand_word());
          else send(FN_ROLLBACK, rand_word());
        end
        default: begin
          // Replayed pops onto an empty stack.
          send(FN_CLEAR, rand_word());
          send(FN_BEGIN, rand_word());
          repeat ($urandom_range(3, 1)) send(FN_POP, rand_word());
          send(FN_PUSH, rand_word());
          repeat (2) send(FN_POP, rand_word());
          send(FN_COMMIT, rand_word());
          send(FN_TOP, rand_word());
        end
      endcase

      if (episode == 3 || $urandom_range(9) == 0) drain_results();
      episode++;
    end

    // Let every outstanding result arrive, then watch a little longer for strays.
    drain_results();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("transactional_stack_top verification clean");
    end else begin
      $display("transactional_stack_top verification failed");
    end
    $finish;
  end

endmodule
